// ===== src/co2c_pkg.sv =====
// ----------------------------------------------------------------------------
// co2c_pkg
// Shared types and constants for the CO2 level classifier: class codes,
// register indexes, the configuration and classifier state records.
// ----------------------------------------------------------------------------
package co2c_pkg;

	// field widths
	localparam int ReadingW = 18;
	localparam int CountW   = 8;
	localparam int CfgIdxW  = 3;

	// air-quality class codes
	typedef enum logic [1:0] {
		CLASS_WARMUP    = 2'd0,
		CLASS_VERY_GOOD = 2'd1,
		CLASS_GOOD      = 2'd2,
		CLASS_BAD       = 2'd3
	} air_class_t;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_WARMUP_LIMIT    = 3'd0,
		REG_VERY_GOOD_LIMIT = 3'd1,
		REG_GOOD_LIMIT      = 3'd2,
		REG_JUMP_LIMIT      = 3'd3,
		REG_PERSIST_COUNT   = 3'd4
	} cfg_index_t;

	// reset values of the configuration registers
	localparam logic [ReadingW-1:0] WarmupLimitRst   = 18'd4800;
	localparam logic [ReadingW-1:0] VeryGoodLimitRst = 18'd11200;
	localparam logic [ReadingW-1:0] GoodLimitRst     = 18'd24000;
	localparam logic [ReadingW-1:0] JumpLimitRst     = 18'd480;
	localparam logic [CountW-1:0]   PersistCountRst  = 8'd2;

	// top value of a band counter
	localparam logic [CountW-1:0] CountMax = '1;

	typedef struct packed {
		logic [ReadingW-1:0] warmup_limit;
		logic [ReadingW-1:0] very_good_limit;
		logic [ReadingW-1:0] good_limit;
		logic [ReadingW-1:0] jump_limit;
		logic [CountW-1:0]   persist_count;
	} cfg_t;

	typedef struct packed {
		logic [ReadingW-1:0] last_reading;
		air_class_t          current_class;
		logic [CountW-1:0]   very_good_runs;
		logic [CountW-1:0]   good_runs;
		logic [CountW-1:0]   bad_runs;
	} cls_state_t;

endpackage

// ===== src/co2_level_classifier.sv =====
// ----------------------------------------------------------------------------
// co2_level_classifier
// Classifies a stream of CO2 readings into air-quality classes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one CO2 reading per transfer, 1/16 ppm unsigned.
//   Master stream m_*: one air class per reading, same order
//   (0 warm-up, 1 very good, 2 good, 3 bad).
//   Config port cfg_*: write limits and persistence count while idle;
//   register index 0..4 in the order warm-up, very good, good, jump,
//   persistence; other indexes are ignored.
// Timing:
//   A reading is registered in the input stage on acceptance and is
//   classified when the pipeline next advances, where the classifier state
//   and the result register update together; m_tvalid is the valid bit of
//   the result register, so the class transfer follows that update.
//   One reading per cycle is sustained while m_tready stays high; the state
//   loop through the compare and counter logic is combinational.
// Reset:
//   Registers return to their default limits, counters and the last
//   reading clear, the class starts as warm-up, both stages empty.
// Stall:
//   When m_tready is low the result holds, the input stage holds one
//   more reading, and s_tready drops once both are full.
// ----------------------------------------------------------------------------
module co2_level_classifier (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [23:0]                         s_tdata,   // [17:0] co2_reading
	// master stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,   // [1:0] air_class
	// configuration write port
	input  logic                                cfg_we,
	input  logic [co2c_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [co2c_pkg::ReadingW-1:0]       cfg_data
);

	co2c_pkg::cfg_t                      cfg_q;
	co2c_pkg::cls_state_t                state_q;
	co2c_pkg::cls_state_t                state_nxt;
	logic                                valid_s1;
	logic [co2c_pkg::ReadingW-1:0]       reading_s1;
	logic                                valid_s2;
	co2c_pkg::air_class_t                class_s2;
	logic                                advance;

	// pipeline moves when the result register is free or being taken
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warmup_limit    <= co2c_pkg::WarmupLimitRst;
			cfg_q.very_good_limit <= co2c_pkg::VeryGoodLimitRst;
			cfg_q.good_limit      <= co2c_pkg::GoodLimitRst;
			cfg_q.jump_limit      <= co2c_pkg::JumpLimitRst;
			cfg_q.persist_count   <= co2c_pkg::PersistCountRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				co2c_pkg::REG_WARMUP_LIMIT:    cfg_q.warmup_limit    <= cfg_data;
				co2c_pkg::REG_VERY_GOOD_LIMIT: cfg_q.very_good_limit <= cfg_data;
				co2c_pkg::REG_GOOD_LIMIT:      cfg_q.good_limit      <= cfg_data;
				co2c_pkg::REG_JUMP_LIMIT:      cfg_q.jump_limit      <= cfg_data;
				co2c_pkg::REG_PERSIST_COUNT: begin
					cfg_q.persist_count <= cfg_data[co2c_pkg::CountW-1:0];
				end
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			reading_s1 <= s_tdata[co2c_pkg::ReadingW-1:0];
		end
	end

	// classification step
	co2c_step u_step (
		.cfg     (cfg_q),
		.cur     (state_q),
		.reading (reading_s1),
		.nxt     (state_nxt)
	);

	// classifier state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_reading   <= '0;
			state_q.current_class  <= co2c_pkg::CLASS_WARMUP;
			state_q.very_good_runs <= '0;
			state_q.good_runs      <= '0;
			state_q.bad_runs       <= '0;
			valid_s2               <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			class_s2 <= state_nxt.current_class;
		end
	end

	// output stream
	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, class_s2};

endmodule

// ===== src/co2c_step.sv =====
// ----------------------------------------------------------------------------
// co2c_step
// Next-state logic of the classifier for one reading: warm-up test, band
// selection, jump detection and persistence counting.
// ----------------------------------------------------------------------------
module co2c_step (
	input  co2c_pkg::cfg_t                      cfg,
	input  co2c_pkg::cls_state_t                cur,
	input  logic [co2c_pkg::ReadingW-1:0]       reading,
	output co2c_pkg::cls_state_t                nxt
);

	co2c_pkg::air_class_t              band;
	logic [co2c_pkg::ReadingW-1:0]     diff;
	logic [co2c_pkg::CountW-1:0]       vg_runs;
	logic [co2c_pkg::CountW-1:0]       g_runs;
	logic [co2c_pkg::CountW-1:0]       b_runs;
	logic                              vg_over;
	logic                              g_over;
	logic                              b_over;

	// band of the reading, first matching limit wins
	always_comb begin
		priority if (reading < cfg.very_good_limit) begin
			band = co2c_pkg::CLASS_VERY_GOOD;
		end else if (reading < cfg.good_limit) begin
			band = co2c_pkg::CLASS_GOOD;
		end else begin
			band = co2c_pkg::CLASS_BAD;
		end
	end

	// distance to the last accepted reading
	assign diff = (reading >= cur.last_reading) ? reading - cur.last_reading
	                                            : cur.last_reading - reading;

	// bumped counters, saturating at the top
	always_comb begin
		vg_runs = cur.very_good_runs;
		g_runs  = cur.good_runs;
		b_runs  = cur.bad_runs;
		unique case (band)
			co2c_pkg::CLASS_VERY_GOOD: begin
				if (vg_runs != co2c_pkg::CountMax) vg_runs = vg_runs + 1'b1;
			end
			co2c_pkg::CLASS_GOOD: begin
				if (g_runs != co2c_pkg::CountMax) g_runs = g_runs + 1'b1;
			end
			default: begin
				if (b_runs != co2c_pkg::CountMax) b_runs = b_runs + 1'b1;
			end
		endcase
	end

	assign vg_over = vg_runs > cfg.persist_count;
	assign g_over  = g_runs > cfg.persist_count;
	assign b_over  = b_runs > cfg.persist_count;

	// next state
	always_comb begin
		nxt = cur;
		if (reading < cfg.warmup_limit) begin
			nxt.current_class = co2c_pkg::CLASS_WARMUP;
		end else begin
			nxt.last_reading = reading;
			if (diff > cfg.jump_limit) begin
				nxt.current_class  = band;
				nxt.very_good_runs = '0;
				nxt.good_runs      = '0;
				nxt.bad_runs       = '0;
			end else if (vg_over || g_over || b_over) begin
				priority if (vg_over) begin
					nxt.current_class = co2c_pkg::CLASS_VERY_GOOD;
				end else if (g_over) begin
					nxt.current_class = co2c_pkg::CLASS_GOOD;
				end else begin
					nxt.current_class = co2c_pkg::CLASS_BAD;
				end
				nxt.very_good_runs = '0;
				nxt.good_runs      = '0;
				nxt.bad_runs       = '0;
			end else begin
				nxt.very_good_runs = vg_runs;
				nxt.good_runs      = g_runs;
				nxt.bad_runs       = b_runs;
			end
		end
	end

endmodule

// ===== tb/co2c_checker.sv =====
// ----------------------------------------------------------------------------
// co2c_checker
// Watches the reading, class and configuration ports of the CO2 level
// classifier, keeps its own copy of the limits and band counters, predicts
// the class of every accepted reading and compares it with the class
// transfers in order.
// ----------------------------------------------------------------------------
module co2c_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [23:0]                   s_tdata,    // [17:0] co2_reading
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [7:0]                    m_tdata,    // [1:0] air_class
	input  logic                          cfg_we,
	input  logic [co2c_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [co2c_pkg::ReadingW-1:0] cfg_data,
	output int                            mismatches,
	output int                            outstanding
);

	localparam int ReportMax = 10;

	co2c_pkg::cfg_t       limits;
	co2c_pkg::cls_state_t cls;
	co2c_pkg::air_class_t pending_classes[$];

	// band of a reading, tested very good first, then good
	function automatic co2c_pkg::air_class_t band_of_reading(
			input logic [co2c_pkg::ReadingW-1:0] r);
		if (r < limits.very_good_limit) return co2c_pkg::CLASS_VERY_GOOD;
		if (r < limits.good_limit) return co2c_pkg::CLASS_GOOD;
		return co2c_pkg::CLASS_BAD;
	endfunction

	// counter increment that stops at the top
	function automatic logic [co2c_pkg::CountW-1:0] bump_run(
			input logic [co2c_pkg::CountW-1:0] c);
		return (c == co2c_pkg::CountMax) ? c : c + 1'b1;
	endfunction

	function automatic void clear_runs();
		cls.very_good_runs = '0;
		cls.good_runs      = '0;
		cls.bad_runs       = '0;
	endfunction

	// advance the classifier state by one reading, return the class shown
	function automatic co2c_pkg::air_class_t classify_reading(
			input logic [co2c_pkg::ReadingW-1:0] r);
		logic [co2c_pkg::ReadingW-1:0] diff;
		co2c_pkg::air_class_t          band;
		logic                          vg_over, good_over, bad_over;
		if (r < limits.warmup_limit) begin
			cls.current_class = co2c_pkg::CLASS_WARMUP;
		end else begin
			diff = (r >= cls.last_reading) ? r - cls.last_reading : cls.last_reading - r;
			band = band_of_reading(r);
			if (diff > limits.jump_limit) begin
				clear_runs();
				cls.current_class = band;
			end else begin
				case (band)
					co2c_pkg::CLASS_VERY_GOOD:
						cls.very_good_runs = bump_run(cls.very_good_runs);
					co2c_pkg::CLASS_GOOD:
						cls.good_runs = bump_run(cls.good_runs);
					default:
						cls.bad_runs = bump_run(cls.bad_runs);
				endcase
				vg_over   = cls.very_good_runs > limits.persist_count;
				good_over = cls.good_runs > limits.persist_count;
				bad_over  = cls.bad_runs > limits.persist_count;
				if (vg_over) cls.current_class = co2c_pkg::CLASS_VERY_GOOD;
				else if (good_over) cls.current_class = co2c_pkg::CLASS_GOOD;
				else if (bad_over) cls.current_class = co2c_pkg::CLASS_BAD;
				if (vg_over || good_over || bad_over) clear_runs();
			end
			cls.last_reading = r;
		end
		return cls.current_class;
	endfunction

	// register writes, reading predictions and class comparisons
	always @(posedge clk or negedge arst_n) begin
		co2c_pkg::air_class_t want;
		co2c_pkg::air_class_t got;
		if (!arst_n) begin
			limits.warmup_limit    = co2c_pkg::WarmupLimitRst;
			limits.very_good_limit = co2c_pkg::VeryGoodLimitRst;
			limits.good_limit      = co2c_pkg::GoodLimitRst;
			limits.jump_limit      = co2c_pkg::JumpLimitRst;
			limits.persist_count   = co2c_pkg::PersistCountRst;
			cls.last_reading       = '0;
			cls.current_class      = co2c_pkg::CLASS_WARMUP;
			clear_runs();
			pending_classes.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (co2c_pkg::cfg_index_t'(cfg_index))
					co2c_pkg::REG_WARMUP_LIMIT:    limits.warmup_limit = cfg_data;
					co2c_pkg::REG_VERY_GOOD_LIMIT: limits.very_good_limit = cfg_data;
					co2c_pkg::REG_GOOD_LIMIT:      limits.good_limit = cfg_data;
					co2c_pkg::REG_JUMP_LIMIT:      limits.jump_limit = cfg_data;
					co2c_pkg::REG_PERSIST_COUNT:
						limits.persist_count = cfg_data[co2c_pkg::CountW-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				pending_classes.push_back(classify_reading(s_tdata[co2c_pkg::ReadingW-1:0]));
			if (m_tvalid && m_tready) begin
				got = co2c_pkg::air_class_t'(m_tdata[1:0]);
				if (pending_classes.size() == 0) begin
					if (mismatches < ReportMax)
						$display("unexpected class transfer: got %0d", got);
					mismatches++;
				end else begin
					want = pending_classes.pop_front();
					if (got != want) begin
						if (mismatches < ReportMax)
							$display("class mismatch: expected %0d got %0d", want, got);
						mismatches++;
					end
				end
			end
			outstanding = pending_classes.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the CO2 level classifier: directed readings over
// every class and special case, then drifting random readings under a range
// of limit settings, with random gaps and stalls on both streams and one
// long receiver hold-off. Prediction and comparison live in co2c_checker.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MaxReading = 262143;
	localparam int HoldCycles = 200;
	localparam int CycleLimit = 300000;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [23:0]                   s_tdata;    // [17:0] co2_reading
	logic                          m_tvalid;
	logic                          m_tready;
	logic [7:0]                    m_tdata;    // [1:0] air_class
	logic                          cfg_we;
	logic [co2c_pkg::CfgIdxW-1:0]  cfg_index;
	logic [co2c_pkg::ReadingW-1:0] cfg_data;
	int                            mismatches;
	int                            outstanding;

	int          cycle_count;
	int          readings_sent;
	bit          idle_on;
	bit          hold_req;
	int unsigned last_sent;
	int unsigned lim_warm, lim_vg, lim_good, lim_jump;

	co2_level_classifier DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	co2c_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// class receiver: random stalls, one long hold-off on request
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_req = 1'b0;
			end
			stall = idle_on ? $urandom_range(0, 3) : 0;
			repeat (stall) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// one reading transfer after a random gap
	task automatic send_reading(input int unsigned r);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, r[co2c_pkg::ReadingW-1:0]};
		do @(posedge clk); while (!s_tready);
		last_sent = r;
		readings_sent++;
		// idle-free stretch of 40 transfers in every 150
		idle_on = (readings_sent % 150) >= 40;
	endtask

	// stop offering readings and wait until every class has come back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input co2c_pkg::cfg_index_t idx, input int unsigned value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[co2c_pkg::ReadingW-1:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_limits(input int unsigned warm, input int unsigned vg,
			input int unsigned good, input int unsigned jump, input int unsigned persist);
		write_reg(co2c_pkg::REG_WARMUP_LIMIT, warm);
		write_reg(co2c_pkg::REG_VERY_GOOD_LIMIT, vg);
		write_reg(co2c_pkg::REG_GOOD_LIMIT, good);
		write_reg(co2c_pkg::REG_JUMP_LIMIT, jump);
		write_reg(co2c_pkg::REG_PERSIST_COUNT, persist);
		lim_warm = warm;
		lim_vg   = vg;
		lim_good = good;
		lim_jump = jump;
	endtask

	function automatic int unsigned clamp_reading(input int v);
		if (v < 0) return 0;
		if (v > MaxReading) return MaxReading;
		return v;
	endfunction

	// mostly a drift within the jump limit, with limit edges, warm-up and jumps
	function automatic int unsigned pick_reading();
		int unsigned sel, step, edge_lim;
		sel = $urandom_range(0, 99);
		if (sel < 58) begin
			step = (sel < 50) ? $urandom_range(0, lim_jump) : lim_jump + $urandom_range(0, 1);
			return clamp_reading($urandom_range(0, 1) ? int'(last_sent) + int'(step)
				: int'(last_sent) - int'(step));
		end
		if (sel < 72) begin
			case ($urandom_range(0, 2))
				0:       edge_lim = lim_warm;
				1:       edge_lim = lim_vg;
				default: edge_lim = lim_good;
			endcase
			return clamp_reading(int'(edge_lim) + int'($urandom_range(0, 4)) - 2);
		end
		if (sel < 82 && lim_warm > 0) return $urandom_range(0, lim_warm - 1);
		return $urandom_range(0, MaxReading);
	endfunction

	task automatic send_random(input int count);
		repeat (count) send_reading(pick_reading());
	endtask

	task automatic send_span(input int count, input int unsigned lo, input int unsigned hi);
		repeat (count) send_reading($urandom_range(lo, hi));
	endtask

	// stimulus
	initial begin
		int unsigned a, b;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		idle_on       = 1'b1;
		hold_req      = 1'b0;
		readings_sent = 0;
		last_sent     = 0;
		lim_warm      = co2c_pkg::WarmupLimitRst;
		lim_vg        = co2c_pkg::VeryGoodLimitRst;
		lim_good      = co2c_pkg::GoodLimitRst;
		lim_jump      = co2c_pkg::JumpLimitRst;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed readings at the reset limits
		send_reading(0);          // warm-up at the bottom
		send_reading(4799);       // just under the warm-up limit
		send_reading(4800);       // jump into very good
		send_reading(4800);
		send_reading(5000);
		send_reading(5200);       // very good count passes persistence
		send_reading(11199);      // jump, top of very good
		send_reading(11200);      // good band at its lower edge
		send_reading(11400);
		send_reading(11600);      // good count passes persistence
		send_reading(MaxReading); // jump to bad at the top
		send_reading(MaxReading);
		send_reading(262000);
		send_reading(261800);     // bad count passes persistence
		send_reading(4799);       // warm-up keeps counters and last reading
		send_reading(261800);     // no counter over, class stays warm-up
		send_reading(23999);      // jump into good
		send_reading(24000);      // bad band at its lower edge
		send_reading(24480);      // difference equal to the jump limit
		send_reading(24961);      // one over the jump limit
		send_reading(131072);
		send_reading(87381);
		send_reading(174762);
		drain();

		// defaults with the long receiver hold-off
		send_random(60);
		hold_req = 1'b1;
		send_random(240);
		drain();

		// no warm-up, every in-band reading sets the class
		set_limits(0, 11200, 24000, 480, 0);
		send_random(150);
		drain();

		// random ordered limits, small persistence
		a = $urandom_range(1, 100000);
		b = $urandom_range(a, 200000);
		set_limits($urandom_range(0, a), a, b, $urandom_range(0, 3000),
			$urandom_range(0, 10));
		send_random(200);
		drain();

		// misordered band limits
		set_limits(2000, 30000, 10000, 1500, 3);
		send_random(150);
		drain();

		// extremes: almost everything is warm-up, no jump tolerance
		set_limits(MaxReading, MaxReading, 0, 0, 254);
		send_span(20, MaxReading - 3, MaxReading);
		send_random(60);
		drain();

		// build several counters, then lower persistence
		set_limits(0, 1000, 2000, MaxReading, 254);
		send_span(150, 0, 3000);
		drain();
		write_reg(co2c_pkg::REG_PERSIST_COUNT, 1);
		send_span(30, 0, 3000);
		drain();
		write_reg(co2c_pkg::REG_PERSIST_COUNT, 254);
		send_span(120, 1000, 3000);
		drain();
		write_reg(co2c_pkg::REG_PERSIST_COUNT, 0);
		send_span(30, 1000, 3000);
		drain();

		// persistence at the top, very good counter saturates
		set_limits(0, MaxReading, MaxReading, MaxReading, 255);
		send_span(300, 0, MaxReading - 1);
		drain();

		// random limits over the full range
		set_limits($urandom_range(0, 20000), $urandom_range(0, MaxReading),
			$urandom_range(0, MaxReading), $urandom_range(0, 20000), $urandom_range(0, 254));
		send_random(250);
		drain();

		repeat (10) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
